/* hdl/yhd_pkg.sv */
// Package for the YUV 4:2:0 half-size downscaler.
// Holds field widths, reset values, register indexes, plane codes and the
// stage item type; depends on nothing.
`default_nettype none
package yhd_pkg;

  localparam int PIX_W         = 8;
  localparam int SUM_W         = 9;
  localparam int PLANE_W       = 2;
  localparam int ROW_W         = 12;
  localparam int HEIGHT_W      = 13;
  localparam int WIDTH_REG_W   = 10;
  localparam int CFG_W         = 13;
  localparam int CFG_INDEX_W   = 2;
  localparam int MAX_HEIGHT    = 4096;
  localparam int DEF_MAX_WIDTH = 512;

  localparam int RST_WIDTH  = 352;
  localparam int RST_HEIGHT = 288;

  localparam logic MODE_DECIMATE = 1'b0;
  localparam logic MODE_AVERAGE  = 1'b1;
  localparam logic RST_MODE      = MODE_AVERAGE;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef enum logic [PLANE_W-1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  // One result on its way from the sequencer to the output stage.
  typedef struct packed {
    logic               avg;
    logic [PIX_W-1:0]   pixel;
    logic [SUM_W-1:0]   pair;
    logic [PLANE_W-1:0] plane;
    logic               frame_end;
  } stage_item_t;

endpackage
`default_nettype wire

/* hdl/yhd_if.sv */
// Stream interfaces for the downscaler's input and result channels.
// Depends on yhd_pkg for the payload widths.
`default_nettype none
interface yhd_in_if;
  logic                     valid;
  logic                     ready;
  logic [yhd_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface yhd_out_if;
  logic                       valid;
  logic                       ready;
  logic [yhd_pkg::PIX_W-1:0]   pixel_out;
  logic [yhd_pkg::PLANE_W-1:0] plane_out;
  logic                       frame_end;

  modport source (output valid, output pixel_out, output plane_out, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_out, input plane_out, input frame_end,
                  output ready);
endinterface
`default_nettype wire

/* hdl/yhd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module yhd_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/yhd_seq.sv */
// Configuration registers, raster counters and per-item decode.
// Depends on yhd_pkg; drives the line store and feeds yhd_out.
`default_nettype none
module yhd_seq #(
  parameter int MAX_WIDTH = yhd_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [yhd_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [yhd_pkg::CFG_W-1:0]       wr_data,
  input  wire logic                            accept,
  input  wire logic [yhd_pkg::PIX_W-1:0]       pixel,
  output logic                                 res_valid,
  output yhd_pkg::stage_item_t                 item,
  output logic                                 line_we,
  output logic                                 line_re,
  output logic [$clog2(MAX_WIDTH)-2:0]         line_addr,
  output logic [yhd_pkg::SUM_W-1:0]            line_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = yhd_pkg::HEIGHT_W;

  function automatic logic [WW-1:0] sat_width(input logic [yhd_pkg::WIDTH_REG_W-1:0] v);
    logic [yhd_pkg::HEIGHT_W-1:0] w;
    w = {3'b000, v[yhd_pkg::WIDTH_REG_W-1:2], 2'b00};
    if (w < 13'd4) begin
      w = 13'd4;
    end else if (w > 13'(MAX_WIDTH)) begin
      w = 13'(MAX_WIDTH) & ~13'd3;
    end
    return w[WW-1:0];
  endfunction

  function automatic logic [HW-1:0] sat_height(input logic [HW-1:0] v);
    logic [HW-1:0] h;
    h = {v[HW-1:2], 2'b00};
    if (h < 13'd4) begin
      h = 13'd4;
    end else if (h > 13'(yhd_pkg::MAX_HEIGHT)) begin
      h = 13'(yhd_pkg::MAX_HEIGHT);
    end
    return h;
  endfunction

  logic                       mode;
  logic [WW-1:0]              width_eff;
  logic [HW-1:0]              height_eff;
  logic [CW-1:0]              col;
  logic [yhd_pkg::ROW_W-1:0]  row;
  yhd_pkg::plane_t            plane;
  logic [yhd_pkg::PIX_W-1:0]  held;

  logic [CW-1:0]              col_next;
  logic [yhd_pkg::ROW_W-1:0]  row_next;
  yhd_pkg::plane_t            plane_next;

  logic [WW-1:0] w_p;
  logic [HW-1:0] h_p;
  logic [WW-1:0] col_w;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_h;
  logic [HW-1:0] row_inc;
  logic          dec_hit;
  logic          avg_hit;
  logic          last_plane;
  logic          fe_dec;
  logic          fe_avg;

  always_comb begin
    w_p        = (plane != yhd_pkg::PLANE_Y) ? (width_eff >> 1) : width_eff;
    h_p        = (plane != yhd_pkg::PLANE_Y) ? (height_eff >> 1) : height_eff;
    col_w      = WW'(col);
    col_inc    = col_w + WW'(1);
    row_h      = HW'(row);
    row_inc    = row_h + HW'(1);
    last_plane = (plane == yhd_pkg::PLANE_V);

    dec_hit = !col[0] && !row[0] && (mode == yhd_pkg::MODE_DECIMATE);
    avg_hit =  col[0] &&  row[0] && (mode == yhd_pkg::MODE_AVERAGE);
    fe_dec  = last_plane && (row_h == h_p - HW'(2)) && (col_w == w_p - WW'(2));
    fe_avg  = last_plane && (row_h == h_p - HW'(1)) && (col_w == w_p - WW'(1));

    res_valid      = dec_hit || avg_hit;
    item.avg       = avg_hit;
    item.pixel     = pixel;
    item.pair      = {1'b0, held} + {1'b0, pixel};
    item.plane     = plane;
    item.frame_end = dec_hit ? fe_dec : fe_avg;

    line_addr  = col[CW-1:1];
    line_wdata = item.pair;
    line_we    = accept && col[0] && !row[0];
    line_re    = accept && avg_hit;

    // advance the raster position: column, then row, then plane
    col_next   = col_inc[CW-1:0];
    row_next   = row;
    plane_next = plane;
    if (col_inc >= w_p) begin
      col_next = '0;
      row_next = row_inc[yhd_pkg::ROW_W-1:0];
      if (row_inc >= h_p) begin
        row_next = '0;
        unique case (plane)
          yhd_pkg::PLANE_Y: plane_next = yhd_pkg::PLANE_U;
          yhd_pkg::PLANE_U: plane_next = yhd_pkg::PLANE_V;
          default:          plane_next = yhd_pkg::PLANE_Y;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= yhd_pkg::RST_MODE;
      width_eff  <= sat_width(yhd_pkg::WIDTH_REG_W'(yhd_pkg::RST_WIDTH));
      height_eff <= sat_height(HW'(yhd_pkg::RST_HEIGHT));
      col        <= '0;
      row        <= '0;
      plane      <= yhd_pkg::PLANE_Y;
      held       <= '0;
    end else if (wr_en) begin
      // any valid register write restarts the frame
      unique case (wr_index)
        yhd_pkg::REG_MODE: begin
          mode  <= wr_data[0];
          col   <= '0;
          row   <= '0;
          plane <= yhd_pkg::PLANE_Y;
        end
        yhd_pkg::REG_WIDTH: begin
          width_eff <= sat_width(wr_data[yhd_pkg::WIDTH_REG_W-1:0]);
          col       <= '0;
          row       <= '0;
          plane     <= yhd_pkg::PLANE_Y;
        end
        yhd_pkg::REG_HEIGHT: begin
          height_eff <= sat_height(wr_data);
          col        <= '0;
          row        <= '0;
          plane      <= yhd_pkg::PLANE_Y;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      col   <= col_next;
      row   <= row_next;
      plane <= plane_next;
      if (!col[0]) begin
        held <= pixel;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/yhd_out.sv */
// Stage register and output register with the 2x2 sum completion.
// Depends on yhd_pkg and yhd_out_if; takes line store read data.
`default_nettype none
module yhd_out (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      load,
  input  wire yhd_pkg::stage_item_t      item,
  input  wire logic [yhd_pkg::SUM_W-1:0] line_rdata,
  output logic                           take,
  yhd_out_if.source                      res
);

  yhd_pkg::stage_item_t        stage;
  logic                        stage_valid;
  logic                        out_valid;
  logic [yhd_pkg::PIX_W-1:0]   pixel_reg;
  logic [yhd_pkg::PLANE_W-1:0] plane_reg;
  logic                        fe_reg;

  logic                        out_free;
  logic [yhd_pkg::SUM_W:0]     quad_sum;

  always_comb begin
    out_free = !out_valid || res.ready;
    take     = !stage_valid || out_free;
    quad_sum = {1'b0, line_rdata} + {1'b0, stage.pair};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= stage_valid;
      end
      if (take) begin
        stage_valid <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && load) begin
      stage <= item;
    end
    if (out_free && stage_valid) begin
      pixel_reg <= stage.avg ? quad_sum[yhd_pkg::SUM_W:2] : stage.pixel;
      plane_reg <= stage.plane;
      fe_reg    <= stage.frame_end;
    end
  end

  assign res.valid     = out_valid;
  assign res.pixel_out = pixel_reg;
  assign res.plane_out = plane_reg;
  assign res.frame_end = fe_reg;

endmodule
`default_nettype wire

/* hdl/yuv420_half_downscaler.sv */
// Top level of the YUV 4:2:0 half-size downscaler.
// Depends on yhd_pkg, yhd_if, yhd_ram, yhd_seq and yhd_out.
//
// pix_in takes one source byte per item in raster order: the whole Y plane,
// then U, then V, the chroma planes half the luma width and height. pix_out
// gives one halved pixel per result item, tagged with its plane and with
// frame_end on the last pixel of the frame. The write port (wr_en, wr_index,
// wr_data) sets the mode (decimate or 2x2 truncated average), luma width and
// luma height; any write to a known register restarts the frame at the first
// Y byte, so write only while nothing is in flight.
// One item is accepted per clock while pix_in.ready is high. The result of an
// accepted item is loaded into the stage register, alongside the registered
// line store read, and then into the output register that drives pix_out.
// Items that cause no result leave nothing in the stage register.
// rst clears the counters, restores mode average, 352 x 288, and holds
// pix_in.ready low. The line store needs no clearing: every even row fills
// it before the odd row reads it.
// When pix_out is held off, the stage and output registers keep one result
// each; pix_in.ready drops only once both are full.
`default_nettype none
module yuv420_half_downscaler #(
  parameter int MAX_WIDTH = yhd_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [yhd_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [yhd_pkg::CFG_W-1:0]       wr_data,
  yhd_in_if.sink                               pix_in,
  yhd_out_if.source                            pix_out
);

  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = $clog2(MAX_WIDTH) - 1;

  logic                      accept;
  logic                      take;
  logic                      res_valid;
  yhd_pkg::stage_item_t      item;
  logic                      line_we;
  logic                      line_re;
  logic [AW-1:0]             line_addr;
  logic [yhd_pkg::SUM_W-1:0] line_wdata;
  logic [yhd_pkg::SUM_W-1:0] line_rdata;

  // accept whenever the stage register is free or moves on this cycle;
  // hold off while in reset
  assign pix_in.ready = take && !rst;
  assign accept       = pix_in.valid && pix_in.ready;

  yhd_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .accept     (accept),
    .pixel      (pix_in.pixel_in),
    .res_valid  (res_valid),
    .item       (item),
    .line_we    (line_we),
    .line_re    (line_re),
    .line_addr  (line_addr),
    .line_wdata (line_wdata)
  );

  // pair sums of the even row, one entry per column pair
  yhd_ram #(
    .WIDTH (yhd_pkg::SUM_W),
    .DEPTH (DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_addr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_addr),
    .rdata (line_rdata)
  );

  yhd_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && res_valid),
    .item       (item),
    .line_rdata (line_rdata),
    .take       (take),
    .res        (pix_out)
  );

endmodule
`default_nettype wire
